// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the allow-list design
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ----- src/kalfe_pkg.sv -----
// ----------------------------------------------------------------------------
// kalfe_pkg
// types and operation codes for the key allow-list with oldest-first eviction
// ----------------------------------------------------------------------------
package kalfe_pkg;

    localparam int KEY_BITS   = 256;
    localparam int COUNT_BITS = 8;

    typedef logic [KEY_BITS-1:0] t_key;

    typedef logic [1:0] t_func;

    localparam t_func FN_LOOKUP     = 2'd0;
    localparam t_func FN_TRUST      = 2'd1;
    localparam t_func FN_FORGET     = 2'd2;
    localparam t_func FN_FORGET_ALL = 2'd3;

    typedef struct packed {
        t_func       func;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
    } t_in;

    typedef struct packed {
        logic                  was_present;
        logic                  evicted_oldest;
        logic [COUNT_BITS-1:0] count_after;
    } t_out;

endpackage

// ----- src/kalfe_ram.sv -----
// ----------------------------------------------------------------------------
// kalfe_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module kalfe_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/kalfe_cmp.sv -----
// ----------------------------------------------------------------------------
// kalfe_cmp
// shared key compare unit: full-width equality of a stored entry and the key
// ----------------------------------------------------------------------------
module kalfe_cmp (
    input  kalfe_pkg::t_key i_entry,
    input  kalfe_pkg::t_key i_key,
    input  logic            i_en,
    output logic            o_match
);

    logic [3:0] w_word_eq;

    always_comb begin
        for (int w = 0; w < 4; w++) begin
            w_word_eq[w] = (i_entry[w*64 +: 64] == i_key[w*64 +: 64]);
        end
    end

    assign o_match = i_en & (&w_word_eq);

endmodule

// ----- src/key_allowlist_fifo_evict_unit.sv -----
// ----------------------------------------------------------------------------
// key_allowlist_fifo_evict_unit
// ordered allow-list of 256-bit keys, oldest first, with fifo eviction
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in) carries an operation and a
// key; output channel (o_out_valid / i_out_stall / o_out) returns one result
// per input: was_present, evicted_oldest and the count after the operation.
// Keys live in one ram of ENTRIES x 256 bits; a small sequencer walks it
// with one read per cycle and one shared compare unit.
// Steps per item: forget all clears the count and goes straight to done;
// lookup, and a trust or forget that changes nothing, search linearly; a
// trust append searches, then writes the key at the end; a forget hit at
// position p searches, then compacts the entries after p down by one; a
// trust of a new key on a full list searches, compacts the whole list to
// evict the oldest entry, then appends.
// o_in_stall is high while an item is in flight; the next item may enter
// while a finished result still waits in the output register.
// A stalled result holds; the sequencer waits in its last step until the
// output register is free. Reset empties the list at once, no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_allowlist_fifo_evict_unit #(
    parameter int ENTRIES = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  kalfe_pkg::t_in   i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output kalfe_pkg::t_out  o_out
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_SHIFT  = 3'd2;
    localparam logic [2:0] ST_APPEND = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_pidx, n_pidx;
    logic               r_pend, n_pend;
    logic               r_present, n_present;
    logic               r_evict, n_evict;
    logic               r_out_vld, n_out_vld;
    kalfe_pkg::t_out    r_out, n_out;
    kalfe_pkg::t_func   r_func, n_func;
    kalfe_pkg::t_key    r_key, n_key;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    kalfe_pkg::t_key    w_wdata;
    kalfe_pkg::t_key    w_rdata;
    logic               w_hit;

    kalfe_ram #(
        .WIDTH (kalfe_pkg::KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    kalfe_cmp u_cmp (
        .i_entry (w_rdata),
        .i_key   (r_key),
        .i_en    (r_pend),
        .o_match (w_hit)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pidx    = r_pidx;
        n_pend    = r_pend;
        n_present = r_present;
        n_evict   = r_evict;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        n_func    = r_func;
        n_key     = r_key;
        w_we      = 1'b0;
        w_waddr   = r_pidx - AW'(1);
        w_wdata   = w_rdata;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_func    = i_in.func;
                    n_key     = {i_in.key_word3, i_in.key_word2,
                                 i_in.key_word1, i_in.key_word0};
                    n_present = 1'b0;
                    n_evict   = 1'b0;
                    n_idx     = '0;
                    n_pend    = 1'b0;
                    if (i_in.func == kalfe_pkg::FN_FORGET_ALL) begin
                        n_count = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (w_hit) begin
                    n_present = 1'b1;
                    n_pend    = 1'b0;
                    if (r_func == kalfe_pkg::FN_FORGET) begin
                        n_idx   = CW'(r_pidx) + CW'(1);
                        n_state = ST_SHIFT;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else if (r_idx < r_count) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[AW-1:0];
                    n_idx  = r_idx + CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (r_func == kalfe_pkg::FN_TRUST) begin
                        if (r_count == CW'(ENTRIES)) begin
                            n_evict = 1'b1;
                            n_idx   = CW'(1);
                            n_state = ST_SHIFT;
                        end else begin
                            n_state = ST_APPEND;
                        end
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SHIFT: begin
                // move entry pidx down to pidx-1 while reading the next one
                w_we = r_pend;
                if (r_idx < r_count) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[AW-1:0];
                    n_idx  = r_idx + CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (r_evict) begin
                        n_count = CW'(ENTRIES - 1);
                        n_state = ST_APPEND;
                    end else begin
                        n_count = r_count - CW'(1);
                        n_state = ST_DONE;
                    end
                end
            end
            ST_APPEND: begin
                w_we    = 1'b1;
                w_waddr = r_count[AW-1:0];
                w_wdata = r_key;
                n_count = r_count + CW'(1);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld           = 1'b1;
                    n_out.was_present    = r_present;
                    n_out.evicted_oldest = r_evict;
                    n_out.count_after    = kalfe_pkg::COUNT_BITS'(r_count);
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_pidx    <= n_pidx;
        r_present <= n_present;
        r_evict   <= n_evict;
        r_out     <= n_out;
        r_func    <= n_func;
        r_key     <= n_key;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    `ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(ENTRIES))
    `ASSERT_IMPLY(a_evict_full, i_clk, i_rst_n, o_out_valid && o_out.evicted_oldest,
        !o_out.was_present && o_out.count_after == kalfe_pkg::COUNT_BITS'(ENTRIES))
    `ASSERT_NEXT(a_forget_all, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && i_in.func == kalfe_pkg::FN_FORGET_ALL,
        r_count == '0 && r_state == ST_DONE)
    `ASSERT_IMPLY(a_shift_addr, i_clk, i_rst_n, r_state == ST_SHIFT && r_pend,
        r_pidx != '0)

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the key allow-list with oldest-first eviction
// ----------------------------------------------------------------------------
// Lookups, trusts, forgets and forget-alls go through the valid/stall input.
// Each transfer is predicted by a queue model of the ordered list. Each
// result is checked in order against the oldest pending prediction.
// Directed tests cover the empty list, single-word near misses, a full list
// with eviction and compaction, and a long output hold-off. Random traffic
// then runs from a key pool sized to keep the list near full, under three
// idle mixes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH   = 128;
    localparam int POOL_SIZE    = 224;
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;
    localparam int MAX_REPORTS  = 40;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    kalfe_pkg::t_in  in_data;
    logic out_valid;
    logic out_stall = 1'b0;
    kalfe_pkg::t_out out_data;

    kalfe_pkg::t_key key_list[$];
    kalfe_pkg::t_out pending_results[$];
    kalfe_pkg::t_key key_pool[POOL_SIZE];

    int          error_count   = 0;
    int          result_count  = 0;
    int unsigned send_gap_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_off_left = 0;

    key_allowlist_fifo_evict_unit #(
        .ENTRIES(LIST_DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_data)
    );

    always #10 clk = ~clk;

    function automatic kalfe_pkg::t_key random_key();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic kalfe_pkg::t_key near_miss(input kalfe_pkg::t_key k);
        return k ^ (kalfe_pkg::t_key'(1) << $urandom_range(kalfe_pkg::KEY_BITS - 1));
    endfunction

    // ordered list model, oldest entry at the front
    function automatic kalfe_pkg::t_out predict_allowlist_result(input kalfe_pkg::t_in item);
        kalfe_pkg::t_out r;
        kalfe_pkg::t_key k;
        int              pos;
        r   = '0;
        k   = {item.key_word3, item.key_word2, item.key_word1, item.key_word0};
        pos = -1;
        if (item.func == kalfe_pkg::FN_FORGET_ALL) begin
            key_list.delete();
        end else begin
            foreach (key_list[i]) begin
                if (pos < 0 && key_list[i] === k) begin
                    pos = i;
                end
            end
            r.was_present = (pos >= 0);
            if (item.func == kalfe_pkg::FN_TRUST && pos < 0) begin
                if (key_list.size() >= LIST_DEPTH) begin
                    void'(key_list.pop_front());
                    r.evicted_oldest = 1'b1;
                end
                key_list.push_back(k);
            end else if (item.func == kalfe_pkg::FN_FORGET && pos >= 0) begin
                key_list.delete(pos);
            end
        end
        r.count_after = kalfe_pkg::COUNT_BITS'(key_list.size());
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS) begin
            $display("mismatch at %0t ns, result %0d: %s", $realtime, result_count, msg);
        end
        error_count++;
    endtask

    task automatic send_item(input kalfe_pkg::t_func f, input kalfe_pkg::t_key k);
        int unsigned gap;
        @(negedge clk);
        if ($urandom_range(99) < send_gap_pct) begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 6);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data.func      = f;
        in_data.key_word0 = k[63:0];
        in_data.key_word1 = k[127:64];
        in_data.key_word2 = k[191:128];
        in_data.key_word3 = k[255:192];
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // input transfer -> prediction
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            pending_results.push_back(predict_allowlist_result(in_data));
        end
    end

    // output transfer -> check
    always @(posedge clk) begin
        kalfe_pkg::t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %p with nothing pending", out_data));
            end else begin
                want = pending_results.pop_front();
                if (out_data.was_present !== want.was_present) begin
                    report_mismatch($sformatf("was_present got %b want %b",
                                              out_data.was_present, want.was_present));
                end
                if (out_data.evicted_oldest !== want.evicted_oldest) begin
                    report_mismatch($sformatf("evicted_oldest got %b want %b",
                                              out_data.evicted_oldest, want.evicted_oldest));
                end
                if (out_data.count_after !== want.count_after) begin
                    report_mismatch($sformatf("count_after got %0d want %0d",
                                              out_data.count_after, want.count_after));
                end
            end
            result_count++;
        end
    end

    // receiver stall, with a counted hold-off
    always @(negedge clk) begin
        if (hold_off_left > 0) begin
            out_stall = 1'b1;
            hold_off_left--;
        end else begin
            out_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic test_empty_list();
        send_item(kalfe_pkg::FN_LOOKUP, '0);
        send_item(kalfe_pkg::FN_FORGET, '1);
        send_item(kalfe_pkg::FN_FORGET_ALL, random_key());
    endtask

    task automatic test_basic_ops();
        kalfe_pkg::t_key ka;
        kalfe_pkg::t_key kb;
        kalfe_pkg::t_key kc;
        ka = '1;
        kb = '0;
        kc = random_key();
        send_item(kalfe_pkg::FN_TRUST, ka);
        send_item(kalfe_pkg::FN_TRUST, kb);
        send_item(kalfe_pkg::FN_TRUST, kc);
        send_item(kalfe_pkg::FN_TRUST, kb);
        send_item(kalfe_pkg::FN_LOOKUP, ka);
        send_item(kalfe_pkg::FN_LOOKUP, {kc[255:192] ^ 64'h1, kc[191:0]});
        send_item(kalfe_pkg::FN_LOOKUP, {kc[255:64], ~kc[63:0]});
        send_item(kalfe_pkg::FN_FORGET, near_miss(ka));
        send_item(kalfe_pkg::FN_FORGET, kb);
        send_item(kalfe_pkg::FN_LOOKUP, kb);
        send_item(kalfe_pkg::FN_LOOKUP, kc);
        send_item(kalfe_pkg::FN_FORGET_ALL, '1);
        send_item(kalfe_pkg::FN_LOOKUP, ka);
    endtask

    task automatic test_fill_and_evict();
        kalfe_pkg::t_key fill_keys[LIST_DEPTH + 1];
        foreach (fill_keys[i]) begin
            fill_keys[i] = random_key();
        end
        send_item(kalfe_pkg::FN_FORGET_ALL, '0);
        foreach (fill_keys[i]) begin
            send_item(kalfe_pkg::FN_TRUST, fill_keys[i]);
        end
        send_item(kalfe_pkg::FN_LOOKUP, fill_keys[0]);
        send_item(kalfe_pkg::FN_LOOKUP, fill_keys[1]);
        send_item(kalfe_pkg::FN_TRUST, fill_keys[5]);
        send_item(kalfe_pkg::FN_FORGET, fill_keys[64]);
        send_item(kalfe_pkg::FN_FORGET, fill_keys[LIST_DEPTH]);
        send_item(kalfe_pkg::FN_FORGET, fill_keys[1]);
        send_item(kalfe_pkg::FN_TRUST, fill_keys[64]);
        send_item(kalfe_pkg::FN_LOOKUP, fill_keys[LIST_DEPTH - 1]);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        @(posedge clk);
        hold_off_left = 500;
        repeat (8) begin
            send_item(($urandom_range(1) != 0) ? kalfe_pkg::FN_TRUST : kalfe_pkg::FN_LOOKUP,
                      key_pool[$urandom_range(POOL_SIZE - 1)]);
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items);
        int unsigned       pick;
        kalfe_pkg::t_func  f;
        kalfe_pkg::t_key   k;
        repeat (n_items) begin
            pick = $urandom_range(999);
            if (pick < 4) begin
                f = kalfe_pkg::FN_FORGET_ALL;
            end else if (pick < 300) begin
                f = kalfe_pkg::FN_LOOKUP;
            end else if (pick < 760) begin
                f = kalfe_pkg::FN_TRUST;
            end else begin
                f = kalfe_pkg::FN_FORGET;
            end
            pick = $urandom_range(99);
            k = key_pool[$urandom_range(POOL_SIZE - 1)];
            if (pick >= 95) begin
                k = random_key();
            end else if (pick >= 85) begin
                k = near_miss(k);
            end
            send_item(f, k);
        end
        wait_drained();
    endtask

    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        foreach (key_pool[i]) begin
            key_pool[i] = random_key();
        end
        key_pool[0] = '1;
        key_pool[1] = '0;
        key_pool[2] = near_miss(key_pool[3]);
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_basic_ops();
        test_fill_and_evict();
        test_output_backpressure();

        send_gap_pct   = 25;
        recv_stall_pct = 54;
        test_random_traffic(300);
        send_gap_pct   = 54;
        recv_stall_pct = 25;
        test_random_traffic(300);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random_traffic(300);

        @(negedge clk);
        in_valid = 1'b0;
        wait_drained();
        if (pending_results.size() != 0) begin
            report_mismatch("results still pending at end of run");
        end
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- key_allowlist_fifo_evict_unit.f -----
+incdir+src
src/kalfe_pkg.sv
src/kalfe_ram.sv
src/kalfe_cmp.sv
src/key_allowlist_fifo_evict_unit.sv
verif/tb.sv
